// ===== rtl/pcm_pkg.sv =====
// Shared constants and controller-to-datapath command type for the 1x1 conv MAC.
`timescale 1ns / 1ps

package pcm_pkg;

    localparam int DEF_MAX_IN_CH  = 64;
    localparam int DEF_MAX_OUT_CH = 64;
    // sample_position is 6 bits wide, so no more than 64 input rows are reachable
    localparam int POS_LIMIT      = 64;

    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int VAL_W     = 16;
    localparam int PROD_W    = 32;
    localparam int SUM_W     = 40;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_IN_CH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CH = 2'd1;

    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef struct packed {
        logic             wt_wr;      // write weight from the accepted word
        logic             smp_ld;     // capture sample value
        logic             acc_rd;     // issue one MAC read for channel ch
        logic             emit_ld;    // load output register from sum of channel ch
        logic             emit_last;  // channel ch is the final one of the pixel
        logic             clr_all;    // drop all accumulated sums
        logic [CNT_W-1:0] ch;         // current output channel
        logic [IDX_W-1:0] row;        // current input channel (weight row)
    } t_ctl;

endpackage

// ===== rtl/pcm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module pcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pcm_datapath.sv =====
// Datapath: weight and sum memories, shared multiply-accumulate and output register.
`timescale 1ns / 1ps

module pcm_datapath #(
    parameter int MAX_IN_CH  = pcm_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH = pcm_pkg::DEF_MAX_OUT_CH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pcm_pkg::t_ctl                  i_ctl,
    input  logic [pcm_pkg::IDX_W-1:0]      i_in_index,
    input  logic [pcm_pkg::IDX_W-1:0]      i_out_index,
    input  logic [pcm_pkg::VAL_W-1:0]      i_value,
    input  logic                           i_out_ready,
    output logic                           o_out_free,
    output logic                           o_out_valid,
    output logic [pcm_pkg::M_TDATA_W-1:0]  o_out_data,   // channel[5:0], sum[45:6], zero pad
    output logic                           o_out_last
);

    import pcm_pkg::*;

    localparam int ROWS  = (MAX_IN_CH < POS_LIMIT) ? MAX_IN_CH : POS_LIMIT;
    localparam int WDEP  = ROWS * MAX_OUT_CH;
    localparam int WAW   = (WDEP > 1) ? $clog2(WDEP) : 1;
    localparam int OCW   = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
    localparam int PAD_W = M_TDATA_W - IDX_W - SUM_W;

    logic                    w_wt_we;
    logic [WAW-1:0]          w_wt_waddr;
    logic [WAW-1:0]          w_wt_raddr;
    logic signed [VAL_W-1:0] w_wt;
    logic [SUM_W-1:0]        w_sum_rd;
    logic [SUM_W-1:0]        w_acc_new;
    logic [OCW-1:0]          w_ch;
    logic signed [PROD_W-1:0] w_prod;

    logic signed [VAL_W-1:0] r_sample;
    logic [MAX_OUT_CH-1:0]   r_vld;
    logic                    r_a1_v;
    logic [OCW-1:0]          r_a1_ch;
    logic                    r_a2_v;
    logic [OCW-1:0]          r_a2_ch;
    logic signed [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]        r_acc_old;
    logic                    r_out_v;
    logic [IDX_W-1:0]        r_out_ch;
    logic [SUM_W-1:0]        r_out_sum;
    logic                    r_out_last;

    assign w_ch = i_ctl.ch[OCW-1:0];

    // weights for an index outside the table are dropped
    assign w_wt_we = i_ctl.wt_wr && (32'(i_in_index) < ROWS) && (32'(i_out_index) < MAX_OUT_CH);
    assign w_wt_waddr = WAW'(i_in_index) * WAW'(MAX_OUT_CH) + WAW'(i_out_index);
    assign w_wt_raddr = WAW'(i_ctl.row) * WAW'(MAX_OUT_CH) + WAW'(i_ctl.ch);

    pcm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (WDEP)
    ) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (w_wt_we),
        .i_waddr (w_wt_waddr),
        .i_wdata (i_value),
        .i_raddr (w_wt_raddr),
        .o_rdata (w_wt)
    );

    pcm_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_OUT_CH)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (r_a2_v),
        .i_waddr (r_a2_ch),
        .i_wdata (w_acc_new),
        .i_raddr (w_ch),
        .o_rdata (w_sum_rd)
    );

    assign w_prod    = r_sample * w_wt;
    assign w_acc_new = r_acc_old + {{(SUM_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (i_ctl.smp_ld) begin
            r_sample <= i_value;
        end
        r_a1_ch   <= w_ch;
        r_a2_ch   <= r_a1_ch;
        r_prod    <= w_prod;
        // a sum without its flag set is still at its cleared value
        r_acc_old <= r_vld[r_a1_ch] ? w_sum_rd : '0;
        if (i_ctl.emit_ld) begin
            r_out_ch   <= i_ctl.ch[IDX_W-1:0];
            r_out_sum  <= r_vld[w_ch] ? w_sum_rd : '0;
            r_out_last <= i_ctl.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v  <= 1'b0;
            r_a2_v  <= 1'b0;
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_a1_v <= i_ctl.acc_rd;
            r_a2_v <= r_a1_v;
            if (i_ctl.clr_all) begin
                r_vld <= '0;
            end else if (r_a2_v) begin
                r_vld[r_a2_ch] <= 1'b1;
            end
            if (i_ctl.emit_ld) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_free  = !r_out_v || i_out_ready;
    assign o_out_valid = r_out_v;
    assign o_out_data  = {{PAD_W{1'b0}}, r_out_sum, r_out_ch};
    assign o_out_last  = r_out_last;

`ifndef SYNTHESIS
    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit_ld |-> (!r_out_v || i_out_ready))
        else $error("output register overwritten while a word is pending");

    a_clear_no_pending_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr_all |-> (!r_a1_v && !r_a2_v))
        else $error("sums cleared while an accumulation write is in flight");

    a_emit_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.emit_ld |-> (!r_a1_v && !r_a2_v && !i_ctl.acc_rd))
        else $error("sum read out while accumulation is still running");
`endif

endmodule

// ===== rtl/pcm_ctrl.sv =====
// Controller: configuration registers, channel sequencing and pixel tracking.
`timescale 1ns / 1ps

module pcm_ctrl #(
    parameter int MAX_IN_CH  = pcm_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH = pcm_pkg::DEF_MAX_OUT_CH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_cmd,
    output logic                          o_in_ready,
    input  logic                          i_cfg_valid,
    input  logic [pcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcm_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_out_free,
    output pcm_pkg::t_ctl                 o_ctl
);

    import pcm_pkg::*;

    localparam int ROWS = (MAX_IN_CH < POS_LIMIT) ? MAX_IN_CH : POS_LIMIT;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_DR1  = 3'd2;
    localparam logic [2:0] ST_DR2  = 3'd3;
    localparam logic [2:0] ST_EMRD = 3'd4;
    localparam logic [2:0] ST_EMLD = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_ch, n_ch;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [CFG_W-1:0] r_in_ch;
    logic [CFG_W-1:0] r_out_ch;
    logic [CNT_W-1:0] w_nin;
    logic [CNT_W-1:0] w_nout;
    logic             w_accept;
    logic             w_ch_last;
    logic             w_pix_end;

    always_comb begin
        if (r_in_ch == '0) begin
            w_nin = CNT_W'(1);
        end else if (32'(r_in_ch) > ROWS) begin
            w_nin = CNT_W'(ROWS);
        end else begin
            w_nin = r_in_ch;
        end
        if (r_out_ch == '0) begin
            w_nout = CNT_W'(1);
        end else if (32'(r_out_ch) > MAX_OUT_CH) begin
            w_nout = CNT_W'(MAX_OUT_CH);
        end else begin
            w_nout = r_out_ch;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_ch_last  = ((r_ch + CNT_W'(1)) == w_nout);
    assign w_pix_end  = ((CNT_W'(r_pos) + CNT_W'(1)) >= w_nin);

    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        n_pos   = r_pos;
        o_ctl   = '0;
        o_ctl.ch        = r_ch;
        o_ctl.row       = r_pos;
        o_ctl.emit_last = w_ch_last;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_cmd == CMD_SAMPLE) begin
                        o_ctl.smp_ld = 1'b1;
                        n_state      = ST_ACC;
                    end else begin
                        o_ctl.wt_wr = 1'b1;
                    end
                end
            end
            ST_ACC: begin
                o_ctl.acc_rd = 1'b1;
                if (w_ch_last) begin
                    n_ch    = '0;
                    n_state = ST_DR1;
                end else begin
                    n_ch = r_ch + CNT_W'(1);
                end
            end
            ST_DR1: begin
                n_state = ST_DR2;
            end
            ST_DR2: begin
                // last write of the sample lands at the end of this cycle
                if (w_pix_end) begin
                    n_pos   = '0;
                    n_state = ST_EMRD;
                end else begin
                    n_pos   = r_pos + IDX_W'(1);
                    n_state = ST_IDLE;
                end
            end
            ST_EMRD: begin
                if (i_out_free) begin
                    n_state = ST_EMLD;
                end
            end
            ST_EMLD: begin
                o_ctl.emit_ld = 1'b1;
                if (w_ch_last) begin
                    o_ctl.clr_all = 1'b1;
                    n_ch          = '0;
                    n_state       = ST_IDLE;
                end else begin
                    n_ch    = r_ch + CNT_W'(1);
                    n_state = ST_EMRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_ch    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ch     <= '0;
            r_pos    <= '0;
            r_in_ch  <= CFG_W'(1);
            r_out_ch <= CFG_W'(1);
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
            r_pos   <= n_pos;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_IN_CH:  r_in_ch  <= i_cfg_data;
                    REG_OUT_CH: r_out_ch <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) < ROWS)
        else $error("sample position beyond the weight table");

    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC || r_state == ST_EMLD) |-> (32'(r_ch) < MAX_OUT_CH))
        else $error("channel counter beyond the output channels");

    a_pixel_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMLD && w_ch_last) |=> (r_state == ST_IDLE && r_ch == '0 && r_pos == '0))
        else $error("pixel did not close cleanly after its last result");
`endif

endmodule

// ===== rtl/pointwise_conv_mac.sv =====
// Top level of the 1x1 convolution multiply-accumulate block.
// Usage:
//  - Slave stream: tuser[0] selects the word kind (0 weight write, 1 sample).
//    Weights are written first, at (in_index, out_index); then the samples of a
//    pixel arrive in input-channel order. One word is taken at a time.
//  - Config port: index 0 = in_channels, 1 = out_channels (7 bits each, reset 1);
//    write only while the block is idle. o_cfg_ready is always high.
//  - Master stream: one word per output channel, channel order, tlast on the
//    final channel of the pixel.
// Sequence: a weight write leaves the input ready for the next word. A sample keeps
//  the input closed while one shared 16x16 MAC walks the output channels,
//  one per cycle, then the two-stage read/multiply/add pipeline drains.
//  After the last sample of a pixel each sum leaves in two steps (sum memory
//  read, then output register load); the read waits until the output register is free.
// Reset: synchronous, active low; clears control and the per-channel sum
//  flags, so all sums read as zero at once. The weight memory is not cleared.
// Stall: a pending result holds in the output register; emission pauses and
//  the input stays closed until the pixel's last result is loaded.
`timescale 1ns / 1ps

module pointwise_conv_mac #(
    parameter int MAX_IN_CH  = pcm_pkg::DEF_MAX_IN_CH,
    parameter int MAX_OUT_CH = pcm_pkg::DEF_MAX_OUT_CH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [pcm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // in_index[5:0], out_index[11:6],
                                                         // value[27:12], zero pad
    input  logic                          s_axis_tuser,  // cmd
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [pcm_pkg::M_TDATA_W-1:0] m_axis_tdata,  // channel[5:0], sum[45:6], zero pad
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pcm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcm_pkg::CFG_W-1:0]     i_cfg_data
);

    import pcm_pkg::*;

    t_ctl             w_ctl;
    logic             w_out_free;
    logic [IDX_W-1:0] w_in_index;
    logic [IDX_W-1:0] w_out_index;
    logic [VAL_W-1:0] w_value;

    assign w_in_index  = s_axis_tdata[IDX_W-1:0];
    assign w_out_index = s_axis_tdata[2*IDX_W-1:IDX_W];
    assign w_value     = s_axis_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
    assign o_cfg_ready = 1'b1;

    pcm_ctrl #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_cmd    (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl)
    );

    pcm_datapath #(
        .MAX_IN_CH  (MAX_IN_CH),
        .MAX_OUT_CH (MAX_OUT_CH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .i_in_index  (w_in_index),
        .i_out_index (w_out_index),
        .i_value     (w_value),
        .i_out_ready (m_axis_tready),
        .o_out_free  (w_out_free),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
